@@ hw/rtl/slsl_pkg.sv @@
// ----------------------------------------------------------------------------
// slsl_pkg
// Shared types and codes for the solenoid, lamp and sound latch.
// ----------------------------------------------------------------------------
package slsl_pkg;

  localparam int OffW   = 4;
  localparam int DataW  = 8;
  localparam int SolW   = 18;
  localparam int LampW  = 64;
  localparam int ColN   = 8;
  localparam int RowW   = 8;
  localparam int SndW   = 8;
  localparam int AddrW  = 3;
  localparam int BusW   = 32;

  localparam logic [OffW-1:0] OFF_SOL_A   = 4'd0;
  localparam logic [OffW-1:0] OFF_SOL_B   = 4'd1;
  localparam logic [OffW-1:0] OFF_SND_LO  = 4'd2;
  localparam logic [OffW-1:0] OFF_SND_HI  = 4'd3;

  localparam logic REG_INVERT = 1'b0;
  localparam logic REG_ENABLE = 1'b1;

  typedef struct packed {
    logic [7:0] invert_mask;
    logic       enable;
  } cfg_t;

  typedef struct packed {
    logic [SolW-1:0]  solenoid_bits;
    logic [LampW-1:0] lamp_bits;
    logic [SndW-1:0]  sound_code;
    logic             sound_send;
  } result_t;

endpackage

@@ hw/rtl/slsl_regs.sv @@
// ----------------------------------------------------------------------------
// slsl_regs
// APB-style configuration registers: sound invert mask and sound enable.
// ----------------------------------------------------------------------------
module slsl_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [slsl_pkg::AddrW-1:0]   paddr,
  input  logic [slsl_pkg::BusW-1:0]    pwdata,
  output logic [slsl_pkg::BusW-1:0]    prdata,
  output logic                         pready,
  output slsl_pkg::cfg_t               cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert_mask <= 8'h00;
      cfg.enable      <= 1'b1;
    end else if (wr) begin
      case (paddr[2])
        slsl_pkg::REG_INVERT: cfg.invert_mask <= pwdata[7:0];
        slsl_pkg::REG_ENABLE: cfg.enable      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      slsl_pkg::REG_INVERT: prdata = {24'd0, cfg.invert_mask};
      slsl_pkg::REG_ENABLE: prdata = {31'd0, cfg.enable};
      default:              prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/slsl_latch.sv @@
// ----------------------------------------------------------------------------
// slsl_latch
// Solenoid word, lamp matrix and sound latch state with their update logic.
// ----------------------------------------------------------------------------
module slsl_latch (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [slsl_pkg::OffW-1:0]   off,
  input  logic [slsl_pkg::DataW-1:0]  data,
  input  slsl_pkg::cfg_t              cfg,
  output slsl_pkg::result_t           result
);

  logic [slsl_pkg::SolW-1:0] solenoid_word, solenoid_word_next;
  logic [slsl_pkg::RowW-1:0] lamp_columns [slsl_pkg::ColN];
  logic [slsl_pkg::RowW-1:0] lamp_columns_next [slsl_pkg::ColN];
  logic [slsl_pkg::SndW-1:0] sound_latch, sound_latch_next;
  logic [slsl_pkg::SndW-1:0] last_sent_sound, last_sent_sound_next;
  logic                      send;

  always_comb begin
    solenoid_word_next   = solenoid_word;
    sound_latch_next     = sound_latch;
    last_sent_sound_next = last_sent_sound;
    send                 = 1'b0;
    case (off)
      slsl_pkg::OFF_SOL_A: begin
        solenoid_word_next[17:16] = data[7:6];
        if (data[6]) begin
          solenoid_word_next[11:10] = data[5:4];
        end else begin
          solenoid_word_next[5:4] = data[5:4];
        end
      end
      slsl_pkg::OFF_SOL_B: begin
        if (solenoid_word[16]) begin
          solenoid_word_next[9:6] = data[7:4];
        end else begin
          solenoid_word_next[3:0] = data[7:4];
        end
      end
      slsl_pkg::OFF_SND_LO: begin
        sound_latch_next[3:0] = data[7:4] ^ cfg.invert_mask[3:0];
        if (sound_latch_next != last_sent_sound) begin
          last_sent_sound_next = sound_latch_next;
          send                 = cfg.enable;
        end
      end
      slsl_pkg::OFF_SND_HI: begin
        sound_latch_next[7:4]       = data[7:4] ^ cfg.invert_mask[7:4];
        solenoid_word_next[13:12]   = data[7:6];
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int c = 0; c < slsl_pkg::ColN; c++) begin
      lamp_columns_next[c] = lamp_columns[c];
    end
    for (int i = 0; i < 4; i++) begin
      lamp_columns_next[{off[3], 2'(i)}][off[2:0]] = data[3-i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      solenoid_word   <= '0;
      sound_latch     <= '0;
      last_sent_sound <= '0;
      for (int c = 0; c < slsl_pkg::ColN; c++) begin
        lamp_columns[c] <= '0;
      end
    end else if (step) begin
      solenoid_word   <= solenoid_word_next;
      sound_latch     <= sound_latch_next;
      last_sent_sound <= last_sent_sound_next;
      for (int c = 0; c < slsl_pkg::ColN; c++) begin
        lamp_columns[c] <= lamp_columns_next[c];
      end
    end
  end

  always_comb begin
    result.solenoid_bits = solenoid_word_next;
    for (int c = 0; c < slsl_pkg::ColN; c++) begin
      result.lamp_bits[c*slsl_pkg::RowW +: slsl_pkg::RowW] = lamp_columns_next[c];
    end
    result.sound_code = sound_latch_next;
    result.sound_send = send;
  end

endmodule

@@ hw/rtl/solenoid_lamp_sound_latch_core.sv @@
// ----------------------------------------------------------------------------
// solenoid_lamp_sound_latch_core
// Command write latch: solenoid word, 8x8 lamp matrix, sound command latch.
//
//   channel  | beat                        | handshake
//   ---------+-----------------------------+-------------------------
//   in       | cmd_offset, cmd_data        | in_valid / in_ready
//   out      | solenoid_bits, lamp_bits,   | out_valid / out_ready
//            | sound_code, sound_send      |
//   config   | paddr, pwdata, prdata       | psel, penable, pwrite, pready
//
// One beat per cycle while out_ready holds or the result register is empty.
// The state update between input and result register is combinational.
// Synchronous reset clears both stage valids and all latch state.
// A stalled result holds; the input register still takes a beat while empty.
// ----------------------------------------------------------------------------
module solenoid_lamp_sound_latch_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [slsl_pkg::OffW-1:0]   cmd_offset,
  input  logic [slsl_pkg::DataW-1:0]  cmd_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [slsl_pkg::SolW-1:0]   solenoid_bits,
  output logic [slsl_pkg::LampW-1:0]  lamp_bits,
  output logic [slsl_pkg::SndW-1:0]   sound_code,
  output logic                        sound_send,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slsl_pkg::AddrW-1:0]  paddr,
  input  logic [slsl_pkg::BusW-1:0]   pwdata,
  output logic [slsl_pkg::BusW-1:0]   prdata,
  output logic                        pready
);

  slsl_pkg::cfg_t    cfg;
  slsl_pkg::result_t result;
  slsl_pkg::result_t result_q;

  logic                       in_q_valid;
  logic [slsl_pkg::OffW-1:0]  off_q;
  logic [slsl_pkg::DataW-1:0] data_q;
  logic                       advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_q_valid || advance;

  slsl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  slsl_latch u_latch (
    .clk    (clk),
    .rst    (rst),
    .step   (in_q_valid && advance),
    .off    (off_q),
    .data   (data_q),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      off_q  <= cmd_offset;
      data_q <= cmd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_q_valid && advance) begin
      result_q <= result;
    end
  end

  assign solenoid_bits = result_q.solenoid_bits;
  assign lamp_bits     = result_q.lamp_bits;
  assign sound_code    = result_q.sound_code;
  assign sound_send    = result_q.sound_send;

endmodule

@@ hw/rtl/slsl_checker.sv @@
// ----------------------------------------------------------------------------
// slsl_checker
// Port-level checks for the solenoid, lamp and sound latch.
// ----------------------------------------------------------------------------
module slsl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [slsl_pkg::SolW-1:0]   solenoid_bits,
  input logic [slsl_pkg::LampW-1:0]  lamp_bits,
  input logic [slsl_pkg::SndW-1:0]   sound_code,
  input logic                        sound_send
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(solenoid_bits)
      && $stable(lamp_bits) && $stable(sound_code) && $stable(sound_send))
    else $error("stalled result changed");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without output stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_send_changes_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && sound_send ##1 out_valid && sound_send
      |-> sound_code != $past(sound_code))
    else $error("repeated sound command sent");

endmodule

bind solenoid_lamp_sound_latch_core slsl_checker u_slsl_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .solenoid_bits (solenoid_bits),
  .lamp_bits     (lamp_bits),
  .sound_code    (sound_code),
  .sound_send    (sound_send)
);
